[design/cfbp_pkg.sv]
// Shared types and constants of the clause factor message block.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package cfbp_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_WEIGHT = 2'd0;
    localparam logic [1:0] CFG_SENSE  = 2'd1;
    localparam logic [1:0] CFG_NPREDS = 2'd2;
    localparam logic [1:0] CFG_TUPLES = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WEIGHT_W   = 16;
    localparam int SENSE_W    = 6;
    localparam int NPREDS_W   = 3;
    localparam int TUPLES_W   = 16;
    localparam int PRED_W     = 3;
    localparam int NEFF_W     = 4;   // effective predicate count, up to 7
    localparam int LSE_N      = 32;
    localparam int LSE_IDX_W  = 5;
    localparam int LSE_VAL_W  = 16;

    // ln(1 + e^-d) for d = k/4, sixteen fraction bits
    localparam logic [LSE_VAL_W-1:0] LSE_TABLE [LSE_N] = '{
        16'd45426, 16'd37745, 16'd31069, 16'd25354, 16'd20530, 16'd16510, 16'd13200, 16'd10500,
        16'd8318,  16'd6567,  16'd5170,  16'd4061,  16'd3184,  16'd2493,  16'd1950,  16'd1523,
        16'd1189,  16'd928,   16'd724,   16'd565,   16'd440,   16'd343,   16'd267,   16'd208,
        16'd162,   16'd126,   16'd98,    16'd77,    16'd60,    16'd47,    16'd36,    16'd28
    };

    // Datapath strobes issued by the controller
    typedef struct packed {
        logic load;      // write the input request into the link store
        logic tgt_latch; // take the target predicate, clear the half sums
        logic init_prod; // start a state's product with the factor term
        logic mul;       // multiply one link's message by the tuple count
        logic add;       // add the registered product
        logic lse1;      // compare and difference against the half sum
        logic lse2;      // fold with the correction term
        logic ratio;     // form the saturated outgoing message
    } t_cmd;

endpackage

`default_nettype wire

[design/cfbp_datapath.sv]
// Datapath: link store, state product accumulator, log-sum-exp fold, ratio.
// Depends on cfbp_pkg; driven by cfbp_ctrl strobes.
`default_nettype none

module cfbp_datapath #(
    parameter int MAX_PREDS = 6,
    parameter int MAX_LINKS = 16,
    parameter int MSG_WIDTH = 24,
    parameter int FRAC_BITS = 8,
    parameter int LINK_W    = 4,
    parameter int ACC_W     = 50
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  cfbp_pkg::t_cmd                i_cmd,
    input  wire  [LINK_W-1:0]                   i_wr_idx,
    input  wire  [LINK_W-1:0]                   i_rd_idx,
    input  wire  [MAX_PREDS-1:0]                i_state,
    input  wire  [cfbp_pkg::PRED_W-1:0]         i_pred_index,
    input  wire  signed [MSG_WIDTH-1:0]         i_msg_false,
    input  wire  signed [MSG_WIDTH-1:0]         i_msg_true,
    input  wire  signed [cfbp_pkg::WEIGHT_W-1:0] i_weight,
    input  wire  [MAX_PREDS-1:0]                i_unsat,
    input  wire  [cfbp_pkg::NEFF_W-1:0]         i_neff,
    input  wire  [cfbp_pkg::TUPLES_W-1:0]       i_tuples,
    output logic [cfbp_pkg::PRED_W-1:0]         o_target,
    output logic signed [MSG_WIDTH-1:0]         o_ratio
);

    localparam int PROD_W = MSG_WIDTH + cfbp_pkg::TUPLES_W + 1;
    localparam int RND    = (FRAC_BITS < 16) ? (1 << (15 - FRAC_BITS)) : 0;
    localparam int SH     = 16 - FRAC_BITS;
    localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'((64'sd1 <<< (MSG_WIDTH-1)) - 1);
    localparam logic signed [ACC_W:0] SAT_LO = -(ACC_W+1)'(64'sd1 <<< (MSG_WIDTH-1));

    logic [cfbp_pkg::PRED_W-1:0] r_pred_store  [MAX_LINKS];
    logic signed [MSG_WIDTH-1:0] r_false_store [MAX_LINKS];
    logic signed [MSG_WIDTH-1:0] r_true_store  [MAX_LINKS];

    logic [cfbp_pkg::PRED_W-1:0] r_tgt;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_p;
    logic signed [ACC_W-1:0]     r_acc [2];
    logic [1:0]                  r_seen;
    logic signed [ACC_W-1:0]     r_max;
    logic [ACC_W-1:0]            r_d;
    logic                        r_h;
    logic                        r_pair;
    logic signed [MSG_WIDTH-1:0] r_ratio;

    logic [cfbp_pkg::PRED_W-1:0] rd_pred;
    logic signed [MSG_WIDTH-1:0] rd_msg;
    logic [MAX_PREDS-1:0]        s_by_pred;
    logic [MAX_PREDS-1:0]        s_by_tgt;
    logic                        src_bit;
    logic                        h;
    logic signed [cfbp_pkg::TUPLES_W:0] tc_s;
    logic signed [PROD_W-1:0]    n_prod;
    logic signed [ACC_W-1:0]     a_h;
    logic [ACC_W-1:0]            idx_full;
    logic [16:0]                 corr;
    logic signed [ACC_W:0]       diff;

    always_comb begin
        rd_pred   = r_pred_store[i_rd_idx];
        s_by_pred = i_state >> rd_pred;
        src_bit   = ({1'b0, rd_pred} < i_neff) && s_by_pred[0];
        rd_msg    = src_bit ? r_true_store[i_rd_idx] : r_false_store[i_rd_idx];
        tc_s      = $signed({1'b0, i_tuples});
        n_prod    = (rd_pred == r_tgt) ? '0 : PROD_W'(rd_msg * tc_s);
        s_by_tgt  = i_state >> r_tgt;
        h         = ({1'b0, r_tgt} < i_neff) && s_by_tgt[0];
        a_h       = r_acc[h];
        idx_full  = r_d >> (FRAC_BITS - 2);
        if (idx_full < ACC_W'(cfbp_pkg::LSE_N)) begin
            corr = 17'(({1'b0, cfbp_pkg::LSE_TABLE[idx_full[cfbp_pkg::LSE_IDX_W-1:0]]}
                        + 17'(RND)) >> SH);
        end else begin
            corr = '0;
        end
        diff = {r_acc[1][ACC_W-1], r_acc[1]} - {r_acc[0][ACC_W-1], r_acc[0]};
    end

    // Link store: plain registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pred_store[i_wr_idx]  <= i_pred_index;
            r_false_store[i_wr_idx] <= i_msg_false;
            r_true_store[i_wr_idx]  <= i_msg_true;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_pair <= 1'b0;
        end else begin
            if (i_cmd.tgt_latch) begin
                r_seen <= '0;
            end
            if (i_cmd.lse1) begin
                r_pair    <= r_seen[h];
                r_seen[h] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tgt_latch) begin
            r_tgt <= rd_pred;
        end
        if (i_cmd.init_prod) begin
            r_p <= (i_state == i_unsat) ? '0 : ACC_W'(i_weight);
        end
        if (i_cmd.mul) begin
            r_prod <= n_prod;
        end
        if (i_cmd.add) begin
            r_p <= r_p + ACC_W'(r_prod);
        end
        if (i_cmd.lse1) begin
            r_h <= h;
            if (!r_seen[h]) begin
                r_acc[h] <= r_p;
            end
            if (a_h >= r_p) begin
                r_max <= a_h;
                r_d   <= ACC_W'(a_h - r_p);
            end else begin
                r_max <= r_p;
                r_d   <= ACC_W'(r_p - a_h);
            end
        end
        if (i_cmd.lse2 && r_pair) begin
            r_acc[r_h] <= r_max + ACC_W'(corr);
        end
        if (i_cmd.ratio) begin
            if (!(r_seen[0] && r_seen[1])) begin
                r_ratio <= '0;
            end else if (diff > SAT_HI) begin
                r_ratio <= MSG_WIDTH'(SAT_HI);
            end else if (diff < SAT_LO) begin
                r_ratio <= MSG_WIDTH'(SAT_LO);
            end else begin
                r_ratio <= MSG_WIDTH'(diff);
            end
        end
    end

    assign o_target = r_tgt;
    assign o_ratio  = r_ratio;

endmodule

`default_nettype wire

[design/cfbp_ctrl.sv]
// Controller: sequences link loading, state walk, fold and result hand-off.
// Depends on cfbp_pkg; drives cfbp_datapath.
`default_nettype none

module cfbp_ctrl #(
    parameter int MAX_PREDS = 6,
    parameter int MAX_LINKS = 16,
    parameter int LINK_W    = 4,
    parameter int LCNT_W    = 5
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  wire                   i_last_link,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire                   i_stall,
    input  wire  [MAX_PREDS-1:0]  i_full,
    output cfbp_pkg::t_cmd        o_cmd,
    output logic [LINK_W-1:0]     o_wr_idx,
    output logic [LINK_W-1:0]     o_rd_idx,
    output logic [MAX_PREDS-1:0]  o_state,
    output logic [LINK_W-1:0]     o_link,
    output logic                  o_last
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_TGT   = 4'd1;
    localparam logic [3:0] ST_INIT  = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_ADD   = 4'd4;
    localparam logic [3:0] ST_LSE1  = 4'd5;
    localparam logic [3:0] ST_LSE2  = 4'd6;
    localparam logic [3:0] ST_RATIO = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0]           r_st,     n_st;
    logic [LCNT_W-1:0]    r_loaded, n_loaded;
    logic [LINK_W-1:0]    r_k,      n_k;
    logic [LINK_W-1:0]    r_j,      n_j;
    logic [MAX_PREDS-1:0] r_s,      n_s;
    logic                 accept;
    logic                 j_last;
    logic                 k_last;

    assign accept = (r_st == ST_IDLE) && i_valid;
    assign j_last = LCNT_W'(r_j) == (r_loaded - LCNT_W'(1));
    assign k_last = LCNT_W'(r_k) == (r_loaded - LCNT_W'(1));

    always_comb begin
        n_st     = r_st;
        n_loaded = r_loaded;
        n_k      = r_k;
        n_j      = r_j;
        n_s      = r_s;
        o_cmd    = '0;
        o_rd_idx = r_j;
        unique case (r_st)
            ST_IDLE: begin
                if (accept) begin
                    if (r_loaded < LCNT_W'(MAX_LINKS)) begin
                        o_cmd.load = 1'b1;
                        n_loaded   = r_loaded + LCNT_W'(1);
                    end
                    if (i_last_link) begin
                        n_k  = '0;
                        n_st = ST_TGT;
                    end
                end
            end
            ST_TGT: begin
                o_rd_idx        = r_k;
                o_cmd.tgt_latch = 1'b1;
                n_s             = '0;
                n_st            = ST_INIT;
            end
            ST_INIT: begin
                o_cmd.init_prod = 1'b1;
                n_j             = '0;
                n_st            = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_st      = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                if (j_last) begin
                    n_st = ST_LSE1;
                end else begin
                    n_j  = r_j + LINK_W'(1);
                    n_st = ST_MUL;
                end
            end
            ST_LSE1: begin
                o_cmd.lse1 = 1'b1;
                n_st       = ST_LSE2;
            end
            ST_LSE2: begin
                o_cmd.lse2 = 1'b1;
                if (r_s == i_full) begin
                    n_st = ST_RATIO;
                end else begin
                    n_s  = r_s + MAX_PREDS'(1);
                    n_st = ST_INIT;
                end
            end
            ST_RATIO: begin
                o_cmd.ratio = 1'b1;
                n_st        = ST_OUT;
            end
            ST_OUT: begin
                if (!i_stall) begin
                    if (k_last) begin
                        n_loaded = '0;
                        n_st     = ST_IDLE;
                    end else begin
                        n_k  = r_k + LINK_W'(1);
                        n_st = ST_TGT;
                    end
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_loaded <= '0;
            r_k      <= '0;
            r_j      <= '0;
            r_s      <= '0;
        end else begin
            r_st     <= n_st;
            r_loaded <= n_loaded;
            r_k      <= n_k;
            r_j      <= n_j;
            r_s      <= n_s;
        end
    end

    assign o_stall  = r_st != ST_IDLE;
    assign o_valid  = r_st == ST_OUT;
    assign o_wr_idx = r_loaded[LINK_W-1:0];
    assign o_state  = r_s;
    assign o_link   = r_k;
    assign o_last   = k_last;

endmodule

`default_nettype wire

[design/clause_factor_bp_message.sv]
// Top level of the clause factor message block: configuration registers,
// controller and datapath. Depends on cfbp_pkg, cfbp_ctrl, cfbp_datapath.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ----------------------------------
//  link in   input      i_valid / o_stall         pred_index, msg_false, msg_true,
//                                                 last_link
//  message   output     o_valid / i_stall         link_number, target_pred,
//                                                 log_ratio, last_result
//  config    input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A link request without last_link is stored; requests beyond the
// store depth are dropped but a dropped last link still starts the work.
// Each outgoing message walks S = 2^num_preds states, with L stored links: the
// single multiply-add walks every link once per state, then the log-sum-exp
// fold runs in its LSE1 and LSE2 states, before the message hand-off.
// The input stalls from the last link until the final message is taken.
// Synchronous active-low reset clears control and sets the configuration to its
// defaults; the link store holds no reset value.
`default_nettype none

module clause_factor_bp_message #(
    parameter  int MAX_PREDS = 6,
    parameter  int MAX_LINKS = 16,
    parameter  int MSG_WIDTH = 24,
    parameter  int FRAC_BITS = 8,
    localparam int LINK_W    = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire  [cfbp_pkg::PRED_W-1:0]           i_pred_index,
    input  wire  signed [MSG_WIDTH-1:0]           i_msg_false,
    input  wire  signed [MSG_WIDTH-1:0]           i_msg_true,
    input  wire                                   i_last_link,
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic [LINK_W-1:0]                     o_link_number,
    output logic [cfbp_pkg::PRED_W-1:0]           o_target_pred,
    output logic signed [MSG_WIDTH-1:0]           o_log_ratio,
    output logic                                  o_last_result,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [cfbp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [cfbp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int LCNT_W = $clog2(MAX_LINKS + 1);
    // Products: message times tuple count, summed over links, with fold headroom
    localparam int ACC_W  = MSG_WIDTH + cfbp_pkg::TUPLES_W + 1 + LCNT_W + 4;

    logic signed [cfbp_pkg::WEIGHT_W-1:0] r_weight;
    logic [cfbp_pkg::SENSE_W-1:0]         r_sense;
    logic [cfbp_pkg::NPREDS_W-1:0]        r_npreds;
    logic [cfbp_pkg::TUPLES_W-1:0]        r_tuples;

    logic [cfbp_pkg::NEFF_W-1:0] neff;
    logic [MAX_PREDS-1:0]        full;
    logic [MAX_PREDS-1:0]        unsat;

    cfbp_pkg::t_cmd       cmd;
    logic [LINK_W-1:0]    wr_idx;
    logic [LINK_W-1:0]    rd_idx;
    logic [MAX_PREDS-1:0] state;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; the user must write them only while idle, the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= 16'sd256;
            r_sense  <= '0;
            r_npreds <= 3'd1;
            r_tuples <= 16'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cfbp_pkg::CFG_WEIGHT: r_weight <= $signed(i_cfg_data);
                cfbp_pkg::CFG_SENSE:  r_sense  <= i_cfg_data[cfbp_pkg::SENSE_W-1:0];
                cfbp_pkg::CFG_NPREDS: r_npreds <= i_cfg_data[cfbp_pkg::NPREDS_W-1:0];
                cfbp_pkg::CFG_TUPLES: r_tuples <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the predicate count, build the last-state and unsatisfied masks
    always_comb begin
        if ({1'b0, r_npreds} > cfbp_pkg::NEFF_W'(MAX_PREDS)) begin
            neff = cfbp_pkg::NEFF_W'(MAX_PREDS);
        end else begin
            neff = {1'b0, r_npreds};
        end
        for (int i = 0; i < MAX_PREDS; i++) begin
            full[i]  = cfbp_pkg::NEFF_W'(i) < neff;
            unsat[i] = full[i] && !((i < cfbp_pkg::SENSE_W) ? r_sense[i % cfbp_pkg::SENSE_W]
                                                              : 1'b0);
        end
    end

    cfbp_ctrl #(
        .MAX_PREDS (MAX_PREDS),
        .MAX_LINKS (MAX_LINKS),
        .LINK_W    (LINK_W),
        .LCNT_W    (LCNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_link (i_last_link),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_full      (full),
        .o_cmd       (cmd),
        .o_wr_idx    (wr_idx),
        .o_rd_idx    (rd_idx),
        .o_state     (state),
        .o_link      (o_link_number),
        .o_last      (o_last_result)
    );

    cfbp_datapath #(
        .MAX_PREDS (MAX_PREDS),
        .MAX_LINKS (MAX_LINKS),
        .MSG_WIDTH (MSG_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .LINK_W    (LINK_W),
        .ACC_W     (ACC_W)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_wr_idx     (wr_idx),
        .i_rd_idx     (rd_idx),
        .i_state      (state),
        .i_pred_index (i_pred_index),
        .i_msg_false  (i_msg_false),
        .i_msg_true   (i_msg_true),
        .i_weight     (r_weight),
        .i_unsat      (unsat),
        .i_neff       (neff),
        .i_tuples     (r_tuples),
        .o_target     (o_target_pred),
        .o_ratio      (o_log_ratio)
    );

endmodule

`default_nettype wire

[design/cfbp_checker.sv]
// Port-level checks for the clause factor message block, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module cfbp_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_valid,
    input wire o_stall,
    input wire i_last_link,
    input wire o_valid,
    input wire i_stall
);

    // A waiting message stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("message dropped while stalled");

    // Inputs are held off while a message is offered
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while message offered");

    // A link that is not the last produces no message
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_last_link && !o_valid |=> !o_valid)
        else $error("message without last link");

    // Each message is offered once
    a_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("message repeated");

endmodule

bind clause_factor_bp_message cfbp_checker u_cfbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_last_link (i_last_link),
    .o_valid     (o_valid),
    .i_stall     (i_stall)
);

`default_nettype wire
